FILE: rtl/core/mpr_pkg.sv
// Shared constants, types and the divide reciprocal table for the
// missing pixel mean repair block. No dependencies.
`default_nettype none

package mpr_pkg;

  localparam int MPR_MAX_WIDTH  = 1024;
  localparam int MPR_MAX_HEIGHT = 4096;

  localparam int IMG_W_BITS  = 11;
  localparam int IMG_H_BITS  = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int IMG_W_RESET = 1024;
  localparam int IMG_H_RESET = 1024;

  localparam int PIX_W    = 8;
  localparam int CELL_W   = PIX_W + 1;    // bit 8 valid, bits 7..0 grey
  localparam int SUM_W    = 11;           // up to eight 8-bit values
  localparam int CNT_W    = 4;            // 0..8 neighbours
  localparam int DIV_SHIFT = 16;
  localparam int RECIP_W  = DIV_SHIFT + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Which sides of the 3x3 neighborhood lie inside the frame.
  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic last;
  } edge_flags_t;

  // ceil(2^DIV_SHIFT / d); exact floor division for sums below 2^SUM_W.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] d);
    logic [RECIP_W-1:0] r;
    begin
      case (d)
        4'd1:    r = 17'd65536;
        4'd2:    r = 17'd32768;
        4'd3:    r = 17'd21846;
        4'd4:    r = 17'd16384;
        4'd5:    r = 17'd13108;
        4'd6:    r = 17'd10923;
        4'd7:    r = 17'd9363;
        4'd8:    r = 17'd8192;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/missing_pixel_mean_repair.sv
// Top level of the missing pixel repair block: line store, sliding 3x3
// window and masked mean. Depends on mpr_pkg and mpr_ram.
`default_nettype none

// Missing pixel repair. Pixels enter in raster order; a valid pixel leaves
// unchanged, a missing one is replaced by the truncated mean of its valid
// in-frame 3x3 neighbors (0 with no_valid_neighbour set when there are
// none). Results trail the requests by image_width + 1 requests, so after
// the last pixel of a frame the source sends image_width + 1 drain
// requests; last_of_frame marks the final result, after which a new frame
// begins. One request is taken per clock while the result side keeps up:
// each pixel request of the frame writes one line store entry (tail
// requests do not) and reads two others (top and middle row of the new
// window column), and the two line store copies serve exactly that. The
// pipe has five register stages (memory read, window, masked sum,
// reciprocal multiply, output register). A stalled output holds the whole
// pipe and drops in_ready. The line store is not cleared after reset:
// positions it is read at are always written earlier in the same frame,
// and others are masked. Register writes take effect at once and restart
// the frame; they are meant for an idle block. Out of range sizes clamp to
// 1..MAX.

module missing_pixel_mean_repair
  import mpr_pkg::*;
#(
  parameter int MAX_WIDTH  = MPR_MAX_WIDTH,
  parameter int MAX_HEIGHT = MPR_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input requests
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [PIX_W-1:0]      in_pixel_in,
  input  wire logic                  in_is_missing,
  input  wire logic                  in_drain,
  // results
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [PIX_W-1:0]      out_pixel_out,
  output logic                       out_repaired,
  output logic                       out_no_valid_neighbour,
  output logic                       out_last_of_frame,
  // register writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RING = 2 * MAX_WIDTH + 3;          // line store depth
  localparam int AW   = $clog2(RING);
  localparam int WW   = $clog2(MAX_WIDTH + 1);      // holds the width
  localparam int CW   = $clog2(MAX_WIDTH);          // column index
  localparam int HW   = $clog2(MAX_HEIGHT + 3);     // rows, incl. drain rows
  localparam int W_RST = (IMG_W_RESET > MAX_WIDTH)  ? MAX_WIDTH  : IMG_W_RESET;
  localparam int H_RST = (IMG_H_RESET > MAX_HEIGHT) ? MAX_HEIGHT : IMG_H_RESET;

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  logic [WW-1:0] w_eff_r, w_eff_nxt;
  logic [HW-1:0] h_eff_r, h_eff_nxt;
  logic [AW-1:0] ring_r, ring_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [HW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [HW-1:0] out_row_r, out_row_nxt;
  logic [AW-1:0] wp_r, wp_nxt;               // ring slot of the next request
  logic          out_valid_r;                // result register holds a result

  logic en;                                   // whole pipe advances
  logic in_fire, cfg_fire;
  logic complete, drop, take, emit, last;
  logic [CW:0]   in_col_inc, out_col_inc;
  logic [HW:0]   out_row_inc;
  logic [AW:0]   wp_inc, top_sum, mid_sum;
  logic [AW-1:0] ra_top, ra_mid;
  edge_flags_t   edge_now;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign complete = (in_row_r >= h_eff_r);
  assign drop     = !complete && in_drain;     // early drain is ignored
  assign take     = in_fire && !drop;
  // output lags by width + 1 requests
  assign emit = (in_row_r >= HW'(2)) || ((in_row_r == HW'(1)) && (in_col_r != '0));

  assign in_col_inc  = {1'b0, in_col_r} + 1'b1;
  assign out_col_inc = {1'b0, out_col_r} + 1'b1;
  assign out_row_inc = {1'b0, out_row_r} + 1'b1;
  assign wp_inc      = {1'b0, wp_r} + 1'b1;

  assign edge_now.top_ok   = (out_row_r != '0);
  assign edge_now.bot_ok   = (out_row_inc < {1'b0, h_eff_r});
  assign edge_now.left_ok  = (out_col_r != '0);
  assign edge_now.right_ok = (out_col_inc < (CW + 1)'(w_eff_r));
  assign edge_now.last     = !edge_now.right_ok && !edge_now.bot_ok;
  assign last = emit && edge_now.last;

  // New window column: row above at slot wp+3, own row at wp-w (mod ring);
  // the row below is the request itself.
  assign top_sum = {1'b0, wp_r} + (AW + 1)'(3);
  assign ra_top  = (top_sum >= {1'b0, ring_r}) ? AW'(top_sum - {1'b0, ring_r})
                                               : top_sum[AW-1:0];
  assign mid_sum = ({1'b0, wp_r} >= (AW + 1)'(w_eff_r))
                 ? ({1'b0, wp_r} - (AW + 1)'(w_eff_r))
                 : ({1'b0, wp_r} + {1'b0, ring_r} - (AW + 1)'(w_eff_r));
  assign ra_mid  = mid_sum[AW-1:0];

  always_comb begin
    w_eff_nxt   = w_eff_r;
    h_eff_nxt   = h_eff_r;
    ring_nxt    = ring_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    wp_nxt      = wp_r;
    if (cfg_fire) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (cfg_data[IMG_W_BITS-1:0] == '0) begin
            w_eff_nxt = WW'(1);
          end else if (cfg_data[IMG_W_BITS-1:0] > MAX_WIDTH) begin
            w_eff_nxt = WW'(MAX_WIDTH);
          end else begin
            w_eff_nxt = WW'(cfg_data[IMG_W_BITS-1:0]);
          end
          ring_nxt = AW'({w_eff_nxt, 1'b0} + (WW + 1)'(3));
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_data[IMG_H_BITS-1:0] == '0) begin
            h_eff_nxt = HW'(1);
          end else if (cfg_data[IMG_H_BITS-1:0] > MAX_HEIGHT) begin
            h_eff_nxt = HW'(MAX_HEIGHT);
          end else begin
            h_eff_nxt = HW'(cfg_data[IMG_H_BITS-1:0]);
          end
        end
        default: ;
      endcase
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      wp_nxt      = '0;
    end else if (take) begin
      if (in_col_inc >= (CW + 1)'(w_eff_r)) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_inc[CW-1:0];
      end
      wp_nxt = (wp_inc >= {1'b0, ring_r}) ? '0 : wp_inc[AW-1:0];
      if (emit) begin
        if (!edge_now.right_ok) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_inc[HW-1:0];
        end else begin
          out_col_nxt = out_col_inc[CW-1:0];
        end
      end
      if (last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
        wp_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r   <= WW'(W_RST);
      h_eff_r   <= HW'(H_RST);
      ring_r    <= AW'(2 * W_RST + 3);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      wp_r      <= '0;
    end else begin
      w_eff_r   <= w_eff_nxt;
      h_eff_r   <= h_eff_nxt;
      ring_r    <= ring_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      wp_r      <= wp_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Line store: two copies, same writes, one read each
  // ---------------------------------------------------------------------
  logic              ram_we;
  logic [CELL_W-1:0] ram_wdata, top_dout, mid_dout;

  assign ram_we    = take && !complete;
  assign ram_wdata = {!in_is_missing, in_pixel_in};

  mpr_ram #(.WIDTH(CELL_W), .DEPTH(RING)) u_ram_top (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .re    (take),
    .raddr (ra_top),
    .rdata (top_dout)
  );

  mpr_ram #(.WIDTH(CELL_W), .DEPTH(RING)) u_ram_mid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .re    (take),
    .raddr (ra_mid),
    .rdata (mid_dout)
  );

  // ---------------------------------------------------------------------
  // Stage 1: memory read in flight
  // ---------------------------------------------------------------------
  logic              s1_shift_r, s1_emit_r;
  logic [CELL_W-1:0] s1_pix_r;
  edge_flags_t       s1_edge_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_shift_r <= 1'b0;
      s1_emit_r  <= 1'b0;
    end else if (en) begin
      s1_shift_r <= take;
      s1_emit_r  <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pix_r  <= ram_wdata;
      s1_edge_r <= edge_now;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: 3x3 window, row-major, slides one column per request
  // ---------------------------------------------------------------------
  logic [CELL_W-1:0] win_r [9];
  logic              s2_emit_r;
  edge_flags_t       s2_edge_r;

  always_ff @(posedge clk) begin
    if (en && s1_shift_r) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= top_dout;
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= mid_dout;
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_emit_r <= 1'b0;
    end else if (en) begin
      s2_emit_r <= s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_edge_r <= s1_edge_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: masked sum and count of the eight neighbors
  // ---------------------------------------------------------------------
  logic [SUM_W-1:0]  sum_nxt, s3_sum_r;
  logic [CNT_W-1:0]  cnt_nxt, s3_cnt_r;
  logic [CELL_W-1:0] s3_ctr_r;
  logic              s3_emit_r, s3_last_r;

  always_comb begin
    logic in_img;
    sum_nxt = '0;
    cnt_nxt = '0;
    for (int rr = 0; rr < 3; rr++) begin
      for (int cc = 0; cc < 3; cc++) begin
        in_img = !(rr == 0 && !s2_edge_r.top_ok) && !(rr == 2 && !s2_edge_r.bot_ok)
              && !(cc == 0 && !s2_edge_r.left_ok) && !(cc == 2 && !s2_edge_r.right_ok)
              && !(rr == 1 && cc == 1);
        if (in_img && win_r[rr * 3 + cc][PIX_W]) begin
          sum_nxt = sum_nxt + SUM_W'(win_r[rr * 3 + cc][PIX_W-1:0]);
          cnt_nxt = cnt_nxt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_emit_r <= 1'b0;
    end else if (en) begin
      s3_emit_r <= s2_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sum_r  <= sum_nxt;
      s3_cnt_r  <= cnt_nxt;
      s3_ctr_r  <= win_r[4];
      s3_last_r <= s2_edge_r.last;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: sum / count as a multiply by the count's reciprocal
  // ---------------------------------------------------------------------
  logic [PROD_W-1:0] s4_prod_r;
  logic [CELL_W-1:0] s4_ctr_r;
  logic              s4_none_r, s4_emit_r, s4_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_emit_r <= 1'b0;
    end else if (en) begin
      s4_emit_r <= s3_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_prod_r <= PROD_W'(s3_sum_r) * PROD_W'(recip(s3_cnt_r));
      s4_ctr_r  <= s3_ctr_r;
      s4_none_r <= (s3_cnt_r == '0);
      s4_last_r <= s3_last_r;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic [PIX_W-1:0] out_pixel_r;
  logic             out_repaired_r, out_none_r, out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s4_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_repaired_r <= !s4_ctr_r[PIX_W];
      out_none_r     <= !s4_ctr_r[PIX_W] && s4_none_r;
      out_last_r     <= s4_last_r;
      if (s4_ctr_r[PIX_W]) begin
        out_pixel_r <= s4_ctr_r[PIX_W-1:0];
      end else if (s4_none_r) begin
        out_pixel_r <= '0;
      end else begin
        out_pixel_r <= s4_prod_r[DIV_SHIFT +: PIX_W];
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_pixel_out          = out_pixel_r;
  assign out_repaired           = out_repaired_r;
  assign out_no_valid_neighbour = out_none_r;
  assign out_last_of_frame      = out_last_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_wp_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r < ring_r)
    else $error("line store pointer outside ring");

  a_read_not_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (ra_top != wp_r) && (ra_mid != wp_r))
    else $error("line store read collides with write");

  a_out_pos: assert property (@(posedge clk) disable iff (!rst_n)
    ((CW + 1)'(out_col_r) < (CW + 1)'(w_eff_r)) && (out_row_r < h_eff_r))
    else $error("output position outside frame");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fire |=> (in_row_r == '0) && (in_col_r == '0) && (wp_r == '0))
    else $error("register write did not restart frame");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s4_emit_r) && $stable(s1_shift_r))
    else $error("pipe moved while output stalled");

endmodule

`default_nettype wire

FILE: rtl/core/mpr_ram.sv
// Generic simple dual-port RAM: one write port, one read port,
// registered read data. No dependencies.
`default_nettype none

module mpr_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 2051
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb_missing_pixel_mean_repair.sv
// Self-checking testbench for missing_pixel_mean_repair: predicts each repaired
// or passed pixel in a local model of the line store and compares results.
// Depends on mpr_pkg and the block's RTL.
`default_nettype none

module tb_missing_pixel_mean_repair;
  import mpr_pkg::*;

  // Watchdog limit, set with wide margin over the slowest correct run.
  localparam int CYCLE_LIMIT   = 500_000;
  // Pipe is five deep; give it room to empty after the last result.
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS  = 920;
  localparam int IDLE_HEAVY    = 64;
  localparam int IDLE_LIGHT    = 19;
  localparam int RING_CELLS    = 2 * MPR_MAX_WIDTH + 3;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             repaired;
    logic             no_neighbour;
    logic             last;
  } pixel_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      in_pixel_in = '0;
  logic                  in_is_missing = 1'b0;
  logic                  in_drain = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      out_pixel_out;
  logic                  out_repaired;
  logic                  out_no_valid_neighbour;
  logic                  out_last_of_frame;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  missing_pixel_mean_repair uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_pixel_in            (in_pixel_in),
    .in_is_missing          (in_is_missing),
    .in_drain               (in_drain),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_pixel_out          (out_pixel_out),
    .out_repaired           (out_repaired),
    .out_no_valid_neighbour (out_no_valid_neighbour),
    .out_last_of_frame      (out_last_of_frame),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  pixel_result_t pixels_due[$];     // predicted results, oldest first
  pixel_result_t oldest_due;
  int            mismatches = 0;
  int            cycles = 0;
  int            stream_items = 0;  // requests that move the frame along
  int            send_idle_pct = 0;
  int            stall_pct = 0;

  // Local copy of the block's state: raw register values, pixel ring, and
  // the positions of the next arriving and next leaving pixel.
  logic [CELL_W-1:0] line_cells [RING_CELLS];
  int unsigned       width_reg = IMG_W_RESET;
  int unsigned       height_reg = IMG_H_RESET;
  int unsigned       in_col = 0;
  int unsigned       in_row = 0;
  int unsigned       out_col = 0;
  int unsigned       out_row = 0;

  // ---------------------------------------------------------------------------
  // Clock, watchdog, receiver back-pressure
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // stall_pct of 0 gives an unbroken ready stretch
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [PIX_W-1:0] want,
                             input logic [PIX_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        $display("%0t: result with nothing due, expected none got pixel %0d",
                 $time, out_pixel_out);
        mismatches++;
      end else begin
        oldest_due = pixels_due.pop_front();
        check_field("pixel_out", oldest_due.pixel, out_pixel_out);
        check_field("repaired", PIX_W'(oldest_due.repaired), PIX_W'(out_repaired));
        check_field("no_valid_neighbour", PIX_W'(oldest_due.no_neighbour),
                    PIX_W'(out_no_valid_neighbour));
        check_field("last_of_frame", PIX_W'(oldest_due.last),
                    PIX_W'(out_last_of_frame));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // Out-of-range register values clamp to 1..max.
  function automatic int unsigned frame_width();
    if (width_reg == 0) return 1;
    if (width_reg > MPR_MAX_WIDTH) return MPR_MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned frame_height();
    if (height_reg == 0) return 1;
    if (height_reg > MPR_MAX_HEIGHT) return MPR_MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic void restart_frame_counters();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  // Advances the model by one accepted request; returns 1 with the leaving
  // pixel when the request pushes one out (it trails by width + 1 requests).
  function automatic bit predict_repair(input logic [PIX_W-1:0] pix,
                                        input bit miss, input bit drn,
                                        output pixel_result_t res);
    int unsigned       w, h, ring, n, sum, cnt;
    int                dr, dc, rr, cc;
    logic [CELL_W-1:0] slot_val;
    bit                frame_in;
    res = '0;
    w = frame_width();
    h = frame_height();
    ring = 2 * w + 3;
    frame_in = (in_row >= h);
    // drain while pixels are still owed: dropped without effect
    if (!frame_in && drn) return 1'b0;
    n = in_row * w + in_col;
    if (!frame_in) line_cells[n % ring] = miss ? '0 : {1'b1, pix};
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (n < w + 1) return 1'b0;

    slot_val = line_cells[(out_row * w + out_col) % ring];
    if (slot_val[PIX_W]) begin
      res.pixel = slot_val[PIX_W-1:0];
    end else begin
      // masked mean over in-frame, valid neighbors only
      res.repaired = 1'b1;
      sum = 0;
      cnt = 0;
      for (dr = -1; dr <= 1; dr++) begin
        for (dc = -1; dc <= 1; dc++) begin
          rr = int'(out_row) + dr;
          cc = int'(out_col) + dc;
          if ((dr != 0 || dc != 0) && rr >= 0 && rr < int'(h) &&
              cc >= 0 && cc < int'(w)) begin
            slot_val = line_cells[(rr * w + cc) % ring];
            if (slot_val[PIX_W]) begin
              sum += slot_val[PIX_W-1:0];
              cnt++;
            end
          end
        end
      end
      if (cnt == 0) res.no_neighbour = 1'b1;
      else res.pixel = PIX_W'(sum / cnt);
    end

    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) begin
        res.last = 1'b1;
        restart_frame_counters();
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void set_idling(input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct = stall;
  endfunction

  // One input request. Valid stays high into the next call when no gap is
  // drawn, so back-to-back requests never drop valid.
  task automatic send_item(input logic [PIX_W-1:0] pix, input bit miss,
                           input bit drn);
    pixel_result_t res;
    bit            dropped;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_pixel_in   <= pix;
    in_is_missing <= miss;
    in_drain      <= drn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    dropped = drn && (in_row < frame_height());
    if (!dropped) stream_items++;
    if (predict_repair(pix, miss, drn, res)) pixels_due = {pixels_due, res};
  endtask

  // Sender holds off until every predicted result is out and the pipe has
  // had time to empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes only on an idle block; each one restarts the frame.
  task automatic write_register(input cfg_reg_t idx,
                                input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = 32'(data[IMG_W_BITS-1:0]);
    else height_reg = 32'(data);
    restart_frame_counters();
  endtask

  // A well-formed frame at the current size: all pixels, optional stray
  // drains mid-frame, then width + 1 tail requests (drains or pixel requests,
  // which count as drains once the frame is in).
  task automatic send_frame(input int miss_pct, input int noise_pct);
    int unsigned w, h, i;
    w = frame_width();
    h = frame_height();
    for (i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < noise_pct)
        send_item(PIX_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      send_item(PIX_W'($urandom_range(255)), $urandom_range(99) < miss_pct, 1'b0);
    end
    for (i = 0; i <= w; i++)
      send_item(PIX_W'($urandom_range(255)), 1'($urandom_range(1)),
                1'($urandom_range(1)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // 3x3 frame with full-scale values, a missing corner, a missing center, an
  // early drain, a pixel request in the tail and a drain after frame end.
  task automatic test_corner_values();
    set_idling(0, 0);
    write_register(REG_IMAGE_WIDTH, 3);
    write_register(REG_IMAGE_HEIGHT, 3);
    send_item(8'd255, 1'b0, 1'b0);
    send_item(8'd17, 1'b1, 1'b0);
    send_item(8'd0, 1'b0, 1'b0);
    send_item(8'hAA, 1'b0, 1'b1);   // drain too early, dropped
    send_item(8'd255, 1'b1, 1'b0);
    send_item(8'd0, 1'b1, 1'b0);    // center missing
    send_item(8'd128, 1'b1, 1'b0);
    send_item(8'd255, 1'b0, 1'b0);
    send_item(8'd255, 1'b0, 1'b0);
    send_item(8'd99, 1'b1, 1'b0);   // bottom-right corner missing
    send_item(8'd0, 1'b0, 1'b1);
    send_item(8'd0, 1'b0, 1'b1);
    send_item(8'd77, 1'b0, 1'b0);   // pixel request acting as drain
    send_item(8'd255, 1'b1, 1'b1);
    send_item(8'd0, 1'b0, 1'b1);    // new frame already, dropped
  endtask

  // Whole 2x2 frame missing: every pixel flagged, value 0.
  task automatic test_no_valid_neighbour();
    int i;
    set_idling(IDLE_LIGHT, IDLE_LIGHT);
    write_register(REG_IMAGE_WIDTH, 2);
    write_register(REG_IMAGE_HEIGHT, 2);
    for (i = 0; i < 4; i++) send_item(8'hFF, 1'b1, 1'b0);
    for (i = 0; i < 3; i++) send_item(8'h00, 1'b0, 1'b1);
  endtask

  // Mid-frame pause until all results are out, then a restart by a register
  // write in the middle of a frame.
  task automatic test_pause_and_restart();
    int i;
    set_idling(0, IDLE_HEAVY);
    write_register(REG_IMAGE_WIDTH, 5);
    write_register(REG_IMAGE_HEIGHT, 4);
    for (i = 0; i < 26; i++) begin
      if (i == 12) wait_idle();
      send_item(PIX_W'($urandom_range(255)), $urandom_range(99) < 30, i >= 20);
    end
    for (i = 0; i < 9; i++)
      send_item(PIX_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
    write_register(REG_IMAGE_HEIGHT, 2);
    send_frame(40, 0);
  endtask

  // Zero sizes clamp to one; values above the maxima (all data bits set)
  // clamp to the maxima, checked over the start of a frame.
  task automatic test_size_clamps();
    int i;
    set_idling(IDLE_LIGHT, IDLE_LIGHT);
    write_register(REG_IMAGE_WIDTH, 0);
    write_register(REG_IMAGE_HEIGHT, 0);
    send_frame(50, 0);
    // widest row: nothing may leave within the first row
    write_register(REG_IMAGE_WIDTH, {CFG_DATA_W{1'b1}});
    write_register(REG_IMAGE_HEIGHT, 1);
    for (i = 0; i < 20; i++)
      send_item(PIX_W'($urandom_range(255)), $urandom_range(99) < 30, 1'b0);
    // tallest column: no bottom edge and no frame end in the first rows
    write_register(REG_IMAGE_WIDTH, 1);
    write_register(REG_IMAGE_HEIGHT, {CFG_DATA_W{1'b1}});
    for (i = 0; i < 30; i++)
      send_item(PIX_W'($urandom_range(255)), $urandom_range(99) < 60, 1'b0);
  endtask

  // Random small frames cycling through the idling phases; one in ten is cut
  // short and abandoned by the next register write.
  task automatic test_random_frames();
    int          start, frame, miss_pct;
    int unsigned w, h, cut, i;
    start = stream_items;
    frame = 0;
    while (stream_items - start < RANDOM_ITEMS) begin
      case (frame % 4)
        0:       set_idling(0, 0);
        1:       set_idling(IDLE_HEAVY, 0);
        2:       set_idling(0, IDLE_HEAVY);
        default: set_idling(IDLE_LIGHT, IDLE_LIGHT);
      endcase
      w = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      write_register(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
      write_register(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
      case ($urandom_range(4))
        0:       miss_pct = 0;
        1:       miss_pct = 15;
        2:       miss_pct = 50;
        3:       miss_pct = 85;
        default: miss_pct = 100;
      endcase
      if ($urandom_range(9) == 0) begin
        cut = $urandom_range(w * h);
        for (i = 0; i < cut; i++)
          send_item(PIX_W'($urandom_range(255)), $urandom_range(99) < miss_pct,
                    $urandom_range(19) == 0);
      end else begin
        send_frame(miss_pct, 5);
      end
      frame++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_values();
    test_no_valid_neighbour();
    test_pause_and_restart();
    test_size_clamps();
    test_random_frames();
    wait_idle();
    if (mismatches == 0 && pixels_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
